[hdl/rhcv_pkg.sv]
// Shared types, constants and the CRC byte function of the request header CRC validator.
package rhcv_pkg;

    localparam int unsigned ENTRY_BYTES  = 256;
    localparam int unsigned HEADER_BYTES = 32;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    localparam logic [15:0] ENTRY_LIMIT_RST = 16'd720;
    localparam logic [7:0]  ALGO_HIGH_RST   = 8'hFF;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // count * ENTRY_BYTES without wrap, HEADER_BYTES + payload without wrap
    localparam int unsigned PROD_W = 32 + $clog2(ENTRY_BYTES + 1);
    localparam int unsigned FSUM_W = 33;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC       = 3'd0,
        CFG_VERSION     = 3'd1,
        CFG_ALGO_LOW    = 3'd2,
        CFG_ALGO_HIGH   = 3'd3,
        CFG_ENTRY_LIMIT = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        R_OK    = 3'd0,
        R_MAGIC = 3'd1,
        R_ALGO  = 3'd2,
        R_COUNT = 3'd3,
        R_PSIZE = 3'd4,
        R_FSIZE = 3'd5,
        R_CRC   = 3'd6
    } t_reason;

    typedef enum logic {
        K_HEADER = 1'b0,
        K_BYTE   = 1'b1
    } t_kind;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [7:0]  algo_low;
        logic [7:0]  algo_high;
        logic [15:0] entry_limit;
    } t_cfg;

    typedef struct packed {
        t_reason reason;
        logic    empty;
    } t_hdr_res;

    typedef struct packed {
        logic        go;
        t_kind       kind;
        t_hdr_res    hdr;
        logic [31:0] pcrc;
        logic [7:0]  data;
        logic        last;
    } t_step;

    typedef struct packed {
        logic        emit;
        logic        ok;
        t_reason     reason;
        logic [31:0] crc;
    } t_res;

    // reflected CRC-32, one byte, eight bit steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

[hdl/rhcv_hdr_check.sv]
// Header field checks against configuration, limits and derived sizes.
module rhcv_hdr_check import rhcv_pkg::*; (
    input  t_cfg        i_cfg,
    input  logic [31:0] i_magic_word,
    input  logic [15:0] i_format_version,
    input  logic [7:0]  i_sort_code,
    input  logic [31:0] i_entry_count,
    input  logic [31:0] i_payload_bytes,
    input  logic [31:0] i_file_bytes,
    output t_hdr_res    o_hdr
);

    logic [PROD_W-1:0] w_prod;
    logic [FSUM_W-1:0] w_fsum;

    always_comb begin
        w_prod = PROD_W'(i_entry_count) * PROD_W'(ENTRY_BYTES);
        w_fsum = FSUM_W'(HEADER_BYTES) + FSUM_W'(i_payload_bytes);
        o_hdr.empty = (i_payload_bytes == 32'd0);
        // first failing check wins
        priority if (i_magic_word != i_cfg.magic || i_format_version != i_cfg.version) begin
            o_hdr.reason = R_MAGIC;
        end else if (i_sort_code < i_cfg.algo_low || i_sort_code > i_cfg.algo_high) begin
            o_hdr.reason = R_ALGO;
        end else if (i_entry_count > 32'(i_cfg.entry_limit)) begin
            o_hdr.reason = R_COUNT;
        end else if (PROD_W'(i_payload_bytes) != w_prod) begin
            o_hdr.reason = R_PSIZE;
        end else if (FSUM_W'(i_file_bytes) != w_fsum) begin
            o_hdr.reason = R_FSIZE;
        end else begin
            o_hdr.reason = R_OK;
        end
    end

endmodule

[hdl/rhcv_frame.sv]
// Frame state and running CRC; forms the answer for failed or empty headers and for the last byte of a frame.
module rhcv_frame import rhcv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_step i_step,
    output t_res  o_res
);

    logic [31:0] r_crc, n_crc;
    logic [31:0] r_expect, n_expect;
    logic        r_open, n_open;
    logic [31:0] w_crc_next;
    logic [31:0] w_final;

    always_comb begin
        w_crc_next = crc_byte(r_crc, i_step.data);
        w_final    = ~w_crc_next;
        n_crc      = r_crc;
        n_expect   = r_expect;
        n_open     = r_open;
        o_res      = '{emit: 1'b0, ok: 1'b0, reason: R_OK, crc: 32'd0};
        if (i_step.go) begin
            unique case (i_step.kind)
                K_HEADER: begin
                    // a new header drops any open frame
                    n_open = 1'b0;
                    n_crc  = CRC_ONES;
                    if (i_step.hdr.reason != R_OK) begin
                        o_res.emit   = 1'b1;
                        o_res.reason = i_step.hdr.reason;
                    end else if (i_step.hdr.empty) begin
                        o_res.emit   = 1'b1;
                        o_res.ok     = (i_step.pcrc == 32'd0);
                        o_res.reason = (i_step.pcrc == 32'd0) ? R_OK : R_CRC;
                    end else begin
                        n_expect = i_step.pcrc;
                        n_open   = 1'b1;
                    end
                end
                K_BYTE: begin
                    if (r_open) begin
                        n_crc = w_crc_next;
                        if (i_step.last) begin
                            n_open       = 1'b0;
                            n_crc        = CRC_ONES;
                            o_res.emit   = 1'b1;
                            o_res.ok     = (w_final == r_expect);
                            o_res.reason = (w_final == r_expect) ? R_OK : R_CRC;
                            o_res.crc    = w_final;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= CRC_ONES;
            r_expect <= 32'd0;
            r_open   <= 1'b0;
        end else begin
            r_crc    <= n_crc;
            r_expect <= n_expect;
            r_open   <= n_open;
        end
    end

endmodule

[hdl/request_header_crc_validator.sv]
// Top level of the request header CRC validator: registers, handshakes, checks.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_kind, header fields, i_data_byte, i_last_byte
//  out     | output    | o_out_valid / i_out_stall | o_valid_res, o_fail_reason, o_computed_checksum
//  cfg     | input     | i_cfg_we (no wait)     | i_cfg_index, i_cfg_data
//
// One word per cycle unless the output stalls: a word sits in the input register, then the header
// checks or one CRC byte step (eight unrolled bit steps) load the result register.
// An accepted word reaches o_out_valid through the input and result registers; words without an answer
// leave nothing at the output.
// Reset (synchronous, active low) empties both registers, closes the frame and
// restores the register defaults. A stalled result holds; the input register
// still drains unless the result is stalled, so the input stalls only when both are full.
module request_header_crc_validator import rhcv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_kind,
    input  logic [31:0]           i_magic_word,
    input  logic [15:0]           i_format_version,
    input  logic [7:0]            i_sort_code,
    input  logic [31:0]           i_entry_count,
    input  logic [31:0]           i_payload_bytes,
    input  logic [31:0]           i_payload_checksum,
    input  logic [31:0]           i_file_bytes,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_valid_res,
    output logic [2:0]            o_fail_reason,
    output logic [31:0]           o_computed_checksum
);

    t_cfg        r_cfg, n_cfg;
    logic        r_in_vld, n_in_vld;
    logic        r_out_vld, n_out_vld;
    t_kind       r_kind;
    logic [31:0] r_magic;
    logic [15:0] r_version;
    logic [7:0]  r_code;
    logic [31:0] r_count;
    logic [31:0] r_pbytes;
    logic [31:0] r_pcrc;
    logic [31:0] r_fbytes;
    logic [7:0]  r_data;
    logic        r_last;
    logic        r_ok;
    t_reason     r_reason;
    logic [31:0] r_chk;

    logic        w_accept;
    logic        w_advance;
    t_hdr_res    w_hdr;
    t_step       w_step;
    t_res        w_res;

    assign w_advance  = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MAGIC:       n_cfg.magic       = i_cfg_data[31:0];
                CFG_VERSION:     n_cfg.version     = i_cfg_data[15:0];
                CFG_ALGO_LOW:    n_cfg.algo_low    = i_cfg_data[7:0];
                CFG_ALGO_HIGH:   n_cfg.algo_high   = i_cfg_data[7:0];
                CFG_ENTRY_LIMIT: n_cfg.entry_limit = i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    rhcv_hdr_check u_hdr (
        .i_cfg            (r_cfg),
        .i_magic_word     (r_magic),
        .i_format_version (r_version),
        .i_sort_code      (r_code),
        .i_entry_count    (r_count),
        .i_payload_bytes  (r_pbytes),
        .i_file_bytes     (r_fbytes),
        .o_hdr            (w_hdr)
    );

    always_comb begin
        w_step.go   = w_advance;
        w_step.kind = r_kind;
        w_step.hdr  = w_hdr;
        w_step.pcrc = r_pcrc;
        w_step.data = r_data;
        w_step.last = r_last;
    end

    rhcv_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .o_res   (w_res)
    );

    always_comb begin
        n_in_vld = w_accept ? 1'b1 : (w_advance ? 1'b0 : r_in_vld);
        // hold a stalled result, otherwise take the new answer if any
        if (r_out_vld && i_out_stall) begin
            n_out_vld = 1'b1;
        end else begin
            n_out_vld = w_advance && w_res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= '{magic: 32'd0, version: 16'd0, algo_low: 8'd0,
                           algo_high: ALGO_HIGH_RST, entry_limit: ENTRY_LIMIT_RST};
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cfg     <= n_cfg;
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind    <= t_kind'(i_kind);
            r_magic   <= i_magic_word;
            r_version <= i_format_version;
            r_code    <= i_sort_code;
            r_count   <= i_entry_count;
            r_pbytes  <= i_payload_bytes;
            r_pcrc    <= i_payload_checksum;
            r_fbytes  <= i_file_bytes;
            r_data    <= i_data_byte;
            r_last    <= i_last_byte;
        end
        if (w_advance && w_res.emit) begin
            r_ok     <= w_res.ok;
            r_reason <= w_res.reason;
            r_chk    <= w_res.crc;
        end
    end

    assign o_out_valid         = r_out_vld;
    assign o_valid_res         = r_ok;
    assign o_fail_reason       = r_reason;
    assign o_computed_checksum = r_chk;

endmodule

[hdl/rhcv_checker.sv]
// Port-level assertions for the request header CRC validator, bound to the top level.
module rhcv_checker import rhcv_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic                  o_valid_res,
    input logic [2:0]            o_fail_reason,
    input logic [31:0]           o_computed_checksum
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_valid_res)
            && $stable(o_fail_reason) && $stable(o_computed_checksum))
        else $error("stalled result word changed");

    // pass flag and reason agree
    a_pass_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_valid_res == (o_fail_reason == R_OK)))
        else $error("pass flag disagrees with fail reason");

    // checksum only reported when the CRC ran
    a_chk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fail_reason != R_CRC && o_computed_checksum != 32'd0
            |-> o_valid_res)
        else $error("checksum reported for a header-only answer");

    // input stalls only while a result is held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while result side is free");

endmodule

bind request_header_crc_validator rhcv_checker u_rhcv_checker (.*);
